### rtl/core/rotary_position_rotation_defines.svh
// ---------------------------------------------------------------------------
// Rotary position rotation assertion macros
// Concurrent assertion helpers shared by the RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ROTARY_POSITION_ROTATION_DEFINES_SVH
`define ROTARY_POSITION_ROTATION_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotary position rotation assertion failed");
// Next-cycle implication, disabled during reset.
`define RPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotary position rotation assertion failed");
`else
`define RPR_ASSERT_IMP(label, clk, rst, ante, cons)
`define RPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/rpr_pkg.sv
// ---------------------------------------------------------------------------
// Rotary position rotation package
// Shared constants, types and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package rpr_pkg;

  // Number of CORDIC micro-rotations per pair.
  localparam int ROTATION_STEPS = 16;
  localparam int STEP_W = $clog2(ROTATION_STEPS);

  // CORDIC gain compensation 0.607252935 in Q0.30.
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;

  // Angle constants in Q0.32 turns, held in the 34-bit angle accumulator.
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

  // Register indexes of the configuration port.
  localparam logic REG_FIRST_FREQUENCY = 1'b0;
  localparam logic REG_FREQUENCY_RATIO = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] FIRST_FREQUENCY_RESET = 32'd683565276;
  localparam logic [31:0] FREQUENCY_RATIO_RESET = 32'd429496730;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ANGLE  = 8'b0000_0010,
    S_FOLD   = 8'b0000_0100,
    S_ROTATE = 8'b0000_1000,
    S_GAIN_X = 8'b0001_0000,
    S_GAIN_Y = 8'b0010_0000,
    S_FREQ   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  // Controls from the sequencer to the CORDIC unit.
  typedef struct packed {
    logic              load;
    logic              run;
    logic [STEP_W-1:0] idx;
  } cordic_ctrl_t;

  // round(atan(2^-i) / (2*pi) * 2^32).
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      5'd24:   a = 32'd41;
      5'd25:   a = 32'd20;
      5'd26:   a = 32'd10;
      5'd27:   a = 32'd5;
      5'd28:   a = 32'd3;
      5'd29:   a = 32'd1;
      5'd30:   a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/rpr_cordic.sv
// ---------------------------------------------------------------------------
// Rotary position rotation CORDIC unit
// Folds the angle into +-1/4 turn on load, then does one micro-rotation
// per cycle while run is asserted, with a shared shifter and adder set.
// ---------------------------------------------------------------------------
module rpr_cordic (
  input  logic                      clk,
  input  rpr_pkg::cordic_ctrl_t     ctrl,
  input  logic signed [31:0]        x_in,
  input  logic signed [31:0]        y_in,
  input  logic        [31:0]        angle,
  output logic signed [31:0]        x,
  output logic signed [31:0]        y
);

  logic signed [33:0] z;
  logic signed [33:0] z_wrap;
  logic signed [33:0] z_fold;
  logic               flip;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [33:0] atan_i;

  // The Q0.32 angle read as signed, moved by half a turn when it lies
  // beyond a quarter turn; the vector is negated in that case.
  always_comb begin
    z_wrap = {{2{angle[31]}}, angle};
    flip   = (z_wrap > rpr_pkg::QUARTER_TURN) || (z_wrap < -rpr_pkg::QUARTER_TURN);
    if (!flip) begin
      z_fold = z_wrap;
    end else if (z_wrap > 34'sd0) begin
      z_fold = z_wrap - rpr_pkg::HALF_TURN;
    end else begin
      z_fold = z_wrap + rpr_pkg::HALF_TURN;
    end
  end

  // Shift terms of the current micro-rotation, floor rounding.
  assign dx     = y >>> ctrl.idx;
  assign dy     = x >>> ctrl.idx;
  assign atan_i = $signed({2'b00, rpr_pkg::atan_turns(5'(ctrl.idx))});

  // Vector and residual angle registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= flip ? -x_in : x_in;
      y <= flip ? -y_in : y_in;
      z <= z_fold;
    end else if (ctrl.run) begin
      if (z >= 34'sd0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_i;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_i;
      end
    end
  end

endmodule

### rtl/core/rotary_position_rotation.sv
// ---------------------------------------------------------------------------
// Rotary position rotation: one pair at a time, the next taken only after the last is done.
// The sequence is angle multiply, fold, 16 CORDIC steps, two gain multiplies
// and the frequency multiply, all on one multiplier and one CORDIC adder set.
// Synchronous reset restores both registers and the running pair frequency.
// ---------------------------------------------------------------------------
`include "rotary_position_rotation_defines.svh"

module rotary_position_rotation (
  input  logic        clk,
  input  logic        rst,
  // Input pairs.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // x_even [15:0], x_odd [31:16], position [47:32]
  input  logic        s_tlast,   // last_pair
  // Rotated pairs.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // y_even [15:0], y_odd [31:16]
  output logic        m_tlast,   // end_of_vector
  output logic        m_tuser,   // clipped
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rpr_pkg::state_t              state;
  logic [rpr_pkg::STEP_W-1:0]   step;
  logic [31:0]                  first_frequency;
  logic [31:0]                  frequency_ratio;
  logic [31:0]                  pair_frequency;
  logic signed [15:0]           x_even;
  logic signed [15:0]           x_odd;
  logic [15:0]                  position;
  logic                         last_pair;
  logic signed [65:0]           prod;
  logic signed [32:0]           mul_a;
  logic signed [32:0]           mul_b;
  logic signed [65:0]           mul_p;
  logic signed [15:0]           y_even;
  logic                         clip_even;
  logic signed [15:0]           y_odd;
  logic                         clip_odd;
  logic signed [65:0]           round_sum;
  logic signed [21:0]           round_val;
  logic signed [15:0]           sat_val;
  logic                         sat_clip;
  logic                         cfg_write;
  logic                         out_free;
  rpr_pkg::cordic_ctrl_t        cordic_ctrl;
  logic signed [31:0]           cordic_x;
  logic signed [31:0]           cordic_y;

  // Configuration port: writes complete in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == rpr_pkg::REG_FREQUENCY_RATIO) ? frequency_ratio
                                                                : first_frequency;

  assign s_tready = (state == rpr_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      rpr_pkg::S_ANGLE: begin
        mul_a = {17'd0, position};
        mul_b = {1'b0, pair_frequency};
      end
      rpr_pkg::S_GAIN_X: begin
        mul_a = {cordic_x[31], cordic_x};
        mul_b = {1'b0, rpr_pkg::GAIN_Q30};
      end
      rpr_pkg::S_GAIN_Y: begin
        mul_a = {cordic_y[31], cordic_y};
        mul_b = {1'b0, rpr_pkg::GAIN_Q30};
      end
      rpr_pkg::S_FREQ: begin
        mul_a = {1'b0, pair_frequency};
        mul_b = {1'b0, frequency_ratio};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round half up, drop 44 fraction bits, saturate to Q2.13.
  always_comb begin
    round_sum = prod + (66'sd1 <<< 43);
    round_val = round_sum[65:44];
    sat_clip  = !((round_val[21:15] == 7'h00) || (round_val[21:15] == 7'h7f));
    if (!sat_clip) begin
      sat_val = round_val[15:0];
    end else if (round_val[21]) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = 16'sh7fff;
    end
  end

  // CORDIC controls.
  always_comb begin
    cordic_ctrl.load = (state == rpr_pkg::S_FOLD);
    cordic_ctrl.run  = (state == rpr_pkg::S_ROTATE);
    cordic_ctrl.idx  = step;
  end

  rpr_cordic u_cordic (
    .clk   (clk),
    .ctrl  (cordic_ctrl),
    .x_in  ({{2{x_even[15]}}, x_even, 14'd0}),
    .y_in  ({{2{x_odd[15]}}, x_odd, 14'd0}),
    .angle (prod[31:0]),
    .x     (cordic_x),
    .y     (cordic_y)
  );

  // Sequencer, configuration registers and pair frequency.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= rpr_pkg::S_IDLE;
      step            <= '0;
      m_tvalid        <= 1'b0;
      first_frequency <= rpr_pkg::FIRST_FREQUENCY_RESET;
      frequency_ratio <= rpr_pkg::FREQUENCY_RATIO_RESET;
      pair_frequency  <= rpr_pkg::FIRST_FREQUENCY_RESET;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_write) begin
        if (paddr[2] == rpr_pkg::REG_FIRST_FREQUENCY) begin
          first_frequency <= pwdata;
          pair_frequency  <= pwdata;
        end else begin
          frequency_ratio <= pwdata;
        end
      end
      case (state)
        rpr_pkg::S_IDLE: begin
          if (s_tvalid) begin
            state <= rpr_pkg::S_ANGLE;
          end
        end
        rpr_pkg::S_ANGLE: begin
          state <= rpr_pkg::S_FOLD;
        end
        rpr_pkg::S_FOLD: begin
          step  <= '0;
          state <= rpr_pkg::S_ROTATE;
        end
        rpr_pkg::S_ROTATE: begin
          step <= step + 1'b1;
          if (step == rpr_pkg::STEP_W'(rpr_pkg::ROTATION_STEPS - 1)) begin
            state <= rpr_pkg::S_GAIN_X;
          end
        end
        rpr_pkg::S_GAIN_X: begin
          state <= rpr_pkg::S_GAIN_Y;
        end
        rpr_pkg::S_GAIN_Y: begin
          state <= rpr_pkg::S_FREQ;
        end
        rpr_pkg::S_FREQ: begin
          state <= rpr_pkg::S_DONE;
        end
        rpr_pkg::S_DONE: begin
          if (out_free) begin
            m_tvalid       <= 1'b1;
            pair_frequency <= last_pair ? first_frequency : prod[63:32];
            state          <= rpr_pkg::S_IDLE;
          end
        end
        default: begin
          state <= rpr_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Request capture, product register, results and output register.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      x_even    <= s_tdata[15:0];
      x_odd     <= s_tdata[31:16];
      position  <= s_tdata[47:32];
      last_pair <= s_tlast;
    end
    // The frequency product is held while the finished pair waits.
    if (state != rpr_pkg::S_DONE) begin
      prod <= mul_p;
    end
    if (state == rpr_pkg::S_GAIN_Y) begin
      y_even    <= sat_val;
      clip_even <= sat_clip;
    end
    if (state == rpr_pkg::S_FREQ) begin
      y_odd    <= sat_val;
      clip_odd <= sat_clip;
    end
    if ((state == rpr_pkg::S_DONE) && out_free) begin
      m_tdata <= {y_odd, y_even};
      m_tlast <= last_pair;
      m_tuser <= clip_even || clip_odd;
    end
  end

  // The block takes no new request while a pair is in progress.
  `RPR_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // A clipped result carries a saturation bound in at least one element.
  `RPR_ASSERT_IMP(a_clip_at_bound, clk, rst, m_tvalid && m_tuser, m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 || m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000)

  // A finished pair waits while the previous result is still held.
  `RPR_ASSERT_NEXT(a_done_waits, clk, rst, state == rpr_pkg::S_DONE && m_tvalid && !m_tready, state == rpr_pkg::S_DONE)

  // The CORDIC step index stays within the step count.
  `RPR_ASSERT_IMP(a_step_range, clk, rst, state == rpr_pkg::S_ROTATE, step <= rpr_pkg::STEP_W'(rpr_pkg::ROTATION_STEPS - 1))

endmodule
